[hw/rtl/ift_pkg.sv]
// Shared types and constants of the IPv4 fragment tracker.
`default_nettype none

package ift_pkg;

    // Number of fragment cells in the tracking chain.
    localparam int MAX_FRAGMENTS = 16;
    // Width of the fill count, which must also hold MAX_FRAGMENTS itself.
    localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);

    localparam int OFF_W    = 13;
    localparam int LEN_W    = 16;
    localparam int BLK_W    = 13;
    localparam int END_W    = 14;
    localparam int TOTAL_W  = 17;
    localparam int COUNT_W  = 5;

    // Result codes reported with every word.
    typedef enum logic [2:0] {
        ST_STORED      = 3'd0,
        ST_MISALIGNED  = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_SECOND_LAST = 3'd3,
        ST_FULL        = 3'd4,
        ST_CLEARED     = 3'd5
    } t_status;

    // One stored fragment as it moves between neighboring cells.
    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] off;
        logic [BLK_W-1:0] blocks;
    } t_entry;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic             clear;
        logic             insert;
        logic [OFF_W-1:0] off;
        logic [BLK_W-1:0] blocks;
        logic [OFF_W-1:0] last;
    } t_cell_ctrl;

    // Per-cell status returned to the controller.
    typedef struct packed {
        logic dup;
        logic link;
        logic hit;
    } t_cell_flags;

endpackage

`default_nettype wire

[hw/rtl/ift_in_if.sv]
// Input channel of the fragment tracker: valid, ready and the request word.
`default_nettype none

interface ift_in_if;
    import ift_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [OFF_W-1:0] fragment_offset;
    logic [LEN_W-1:0] payload_length;
    logic             more_fragments;

    modport source (
        output valid, op, fragment_offset, payload_length, more_fragments,
        input  ready
    );

    modport sink (
        input  valid, op, fragment_offset, payload_length, more_fragments,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/ift_out_if.sv]
// Output channel of the fragment tracker: valid, ready and the result word.
`default_nettype none

interface ift_out_if;
    import ift_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic               complete;
    logic [TOTAL_W-1:0] total_length;
    logic [COUNT_W-1:0] fragment_count;

    modport source (
        output valid, status, complete, total_length, fragment_count,
        input  ready
    );

    modport sink (
        input  valid, status, complete, total_length, fragment_count,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/ift_cell.sv]
// One cell of the sorted fragment chain: holds a fragment and checks its link.
`default_nettype none

module ift_cell
    import ift_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cell_ctrl  i_ctrl,
    input  wire t_entry      i_prev_entry,
    input  wire logic        i_prev_gt,
    input  wire logic [END_W-1:0] i_prev_end,
    output t_entry           o_entry,
    output logic             o_gt,
    output logic [END_W-1:0] o_end,
    output t_cell_flags      o_flags
);

    logic             r_valid;
    logic [OFF_W-1:0] r_off;
    logic [BLK_W-1:0] r_blocks;
    logic             r_link;
    logic             r_hit;

    t_entry n_entry;
    logic   n_load;

    // This cell sits above the new offset, or is still empty.
    assign o_gt    = !r_valid || (r_off > i_ctrl.off);
    assign o_end   = {1'b0, r_off} + {1'b0, r_blocks};
    assign o_entry = '{valid: r_valid, off: r_off, blocks: r_blocks};

    assign o_flags.dup  = r_valid && (r_off == i_ctrl.off);
    assign o_flags.link = r_link;
    assign o_flags.hit  = r_hit;

    // On an insert, the first cell above the new offset takes it and the
    // cells after it shift up by one, taking their neighbor's fragment.
    always_comb begin
        n_load  = i_ctrl.insert && o_gt;
        n_entry = i_prev_gt ? i_prev_entry
                            : '{valid: 1'b1, off: i_ctrl.off, blocks: i_ctrl.blocks};
    end

    // Valid bit is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= n_entry.valid;
        end
    end

    // Fragment payload.
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_off    <= n_entry.off;
            r_blocks <= n_entry.blocks;
        end
    end

    // Link: this fragment starts where its lower neighbor ends.
    // Hit: this fragment ends at the last offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_link <= r_valid && ({1'b0, r_off} == i_prev_end);
            r_hit  <= r_valid && (o_end == {1'b0, i_ctrl.last});
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ipv4_fragment_tracker.sv]
// Top level of the IPv4 fragment tracker: controller and a chain of cells.
//
// Usage: each word on the input channel either clears the tracker (op = 1)
// or offers one fragment by offset, payload length and more-fragments flag.
// Every input word yields exactly one result word on the output channel with
// a status code, the completeness flag, the datagram length and the number
// of stored fragments.
// Fragments are kept in a row of cells sorted by offset; an insert shifts
// the upper cells by one place, and each cell compares itself with its lower
// neighbor to judge contiguity.
// After its word is accepted, a result passes through the sequencer steps
// update, link check, then gap search and output load, in that order.
// The sequencer walks one word at a time through these steps, so no new
// word is taken until the result of the last one is loaded.
// A new word is accepted while a finished result still waits in the output
// register; if the receiver stalls, the next result waits in its last step
// until the output register is free, and no input is taken meanwhile.
// Reset (synchronous, active low) empties every cell and clears the last
// offset, the datagram length and the fill count.
`default_nettype none

module ipv4_fragment_tracker
    import ift_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ift_in_if.sink    i_in,
    ift_out_if.source o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_LINK,
        S_DONE
    } t_state;

    t_state r_state;

    // Captured request word.
    logic             r_op;
    logic [OFF_W-1:0] r_off;
    logic [LEN_W-1:0] r_len;
    logic             r_mf;

    // Datagram state.
    logic [OFF_W-1:0]   r_last;
    logic [TOTAL_W-1:0] r_dlen;
    logic [CNT_W-1:0]   r_count;
    t_status            r_status;

    // Output register.
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_complete;
    logic [TOTAL_W-1:0] r_out_total;
    logic [COUNT_W-1:0] r_out_count;

    t_cell_ctrl  cell_ctrl;
    t_entry      cell_entry [MAX_FRAGMENTS];
    logic        cell_gt    [MAX_FRAGMENTS];
    logic [END_W-1:0] cell_end [MAX_FRAGMENTS];
    t_cell_flags cell_flags [MAX_FRAGMENTS];

    logic [MAX_FRAGMENTS-1:0] valid_vec;
    logic [MAX_FRAGMENTS-1:0] dup_vec;
    logic [MAX_FRAGMENTS-1:0] link_vec;
    logic [MAX_FRAGMENTS-1:0] hit_vec;

    // Row of cells; cell zero sees an empty neighbor that ends at offset zero.
    for (genvar g = 0; g < MAX_FRAGMENTS; g++) begin : g_cell
        if (g == 0) begin : g_first
            ift_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_prev_entry ('0),
                .i_prev_gt    (1'b0),
                .i_prev_end   ('0),
                .o_entry      (cell_entry[g]),
                .o_gt         (cell_gt[g]),
                .o_end        (cell_end[g]),
                .o_flags      (cell_flags[g])
            );
        end else begin : g_next
            ift_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_prev_entry (cell_entry[g-1]),
                .i_prev_gt    (cell_gt[g-1]),
                .i_prev_end   (cell_end[g-1]),
                .o_entry      (cell_entry[g]),
                .o_gt         (cell_gt[g]),
                .o_end        (cell_end[g]),
                .o_flags      (cell_flags[g])
            );
        end
        assign valid_vec[g] = cell_entry[g].valid;
        assign dup_vec[g]   = cell_flags[g].dup;
        assign link_vec[g]  = cell_flags[g].link;
        assign hit_vec[g]   = cell_flags[g].hit;
    end

    // Decision for the captured fragment.
    logic             misaligned;
    logic             is_dup;
    logic             is_full;
    logic             do_store;
    t_status          n_status;

    always_comb begin
        misaligned = (r_len[2:0] != 3'b000) && !(!r_mf && (r_last == '0));
        is_dup     = |dup_vec;
        is_full    = (r_count == CNT_W'(MAX_FRAGMENTS));
        do_store   = 1'b0;
        priority if (r_op) begin
            n_status = ST_CLEARED;
        end else if (misaligned) begin
            n_status = ST_MISALIGNED;
        end else if (is_dup) begin
            n_status = ST_DUPLICATE;
        end else if (is_full) begin
            n_status = ST_FULL;
        end else begin
            do_store = 1'b1;
            n_status = (!r_mf && (r_last != '0)) ? ST_SECOND_LAST : ST_STORED;
        end
    end

    assign cell_ctrl.clear  = (r_state == S_UPD) && r_op;
    assign cell_ctrl.insert = (r_state == S_UPD) && do_store;
    assign cell_ctrl.off    = r_off;
    assign cell_ctrl.blocks = r_len[LEN_W-1:3];
    assign cell_ctrl.last   = r_last;

    // Contiguity: some cell ends at the last offset and every cell up to it
    // links to its neighbor. Cells below the lowest broken link are good.
    logic [MAX_FRAGMENTS-1:0] bad_vec;
    logic [MAX_FRAGMENTS-1:0] first_bad;
    logic [MAX_FRAGMENTS-1:0] good_vec;
    logic                     complete;

    always_comb begin
        bad_vec   = ~link_vec;
        first_bad = bad_vec & (~bad_vec + MAX_FRAGMENTS'(1));
        good_vec  = first_bad - MAX_FRAGMENTS'(1);
        complete  = (r_last != '0) && (|(hit_vec & good_vec));
    end

    logic [31:0] count_wide;
    assign count_wide = 32'(r_count);

    // Sequencer, datagram state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_dlen      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The final step handles the output register on its own.
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.op;
                        r_off   <= i_in.fragment_offset;
                        r_len   <= i_in.payload_length;
                        r_mf    <= i_in.more_fragments;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_status <= n_status;
                    if (r_op) begin
                        r_last  <= '0;
                        r_dlen  <= '0;
                        r_count <= '0;
                    end else if (do_store) begin
                        r_count <= r_count + CNT_W'(1);
                        if (!r_mf && (r_last == '0)) begin
                            r_last <= r_off;
                            r_dlen <= TOTAL_W'({r_off, 3'b000}) + TOTAL_W'(r_len);
                        end
                    end
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_status   <= r_status;
                        r_out_complete <= complete;
                        r_out_total    <= r_dlen;
                        r_out_count    <= count_wide[COUNT_W-1:0];
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.complete        = r_out_complete;
    assign o_out.total_length    = r_out_total;
    assign o_out.fragment_count  = r_out_count;

    // The fill count matches the occupied cells, which form a solid run
    // from cell zero.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(valid_vec) == 32'(r_count)) &&
        ((valid_vec & (valid_vec + MAX_FRAGMENTS'(1))) == '0))
        else $error("fill count and occupied cells disagree");

    // Adjacent occupied cells stay in rising offset order.
    for (genvar g = 1; g < MAX_FRAGMENTS; g++) begin : g_sorted
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            cell_entry[g].valid |-> (cell_entry[g].off > cell_entry[g-1].off))
            else $error("fragment chain out of order");
    end

    // A result is only loaded from the final step of the sequencer.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the final step");

    // A cleared result reports an empty datagram.
    a_cleared_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_CLEARED)) |->
        ((r_out_count == '0) && !r_out_complete && (r_out_total == '0)))
        else $error("cleared result reports stale datagram state");

endmodule

`default_nettype wire
